[rtl/plc_pkg.sv]
`default_nettype none

package plc_pkg;

    localparam int VALUE_W  = 32;
    localparam int POS_W    = 16;
    localparam int MODE_W   = 3;
    localparam int COUNT_W  = 5;
    localparam int STATUS_W = 2;

    // Command codes
    localparam logic [MODE_W-1:0] MODE_PUSH_FRONT = 3'd0;
    localparam logic [MODE_W-1:0] MODE_PUSH_BACK  = 3'd1;
    localparam logic [MODE_W-1:0] MODE_POP_FRONT  = 3'd2;
    localparam logic [MODE_W-1:0] MODE_POP_BACK   = 3'd3;
    localparam logic [MODE_W-1:0] MODE_INSERT_AT  = 3'd4;
    localparam logic [MODE_W-1:0] MODE_REMOVE_AT  = 3'd5;
    localparam logic [MODE_W-1:0] MODE_COUNT      = 3'd6;

    // Result status codes
    localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_EMPTY = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd2;

    // Shift command broadcast to every cell
    typedef struct packed {
        logic ins;   // open a slot at the index, tail moves up
        logic rem;   // close the slot at the index, tail moves down
    } cell_cmd_t;

endpackage

`default_nettype wire

[rtl/plc_cell.sv]
`default_nettype none

module plc_cell
    import plc_pkg::*;
#(
    parameter int IDX_W = 5,
    parameter int IDX   = 0
) (
    input  wire                       aclk,
    input  wire  cell_cmd_t           cmd,
    input  wire  [IDX_W-1:0]          idx,
    input  wire  signed [VALUE_W-1:0] value_in,
    input  wire  signed [VALUE_W-1:0] left_val,
    input  wire  signed [VALUE_W-1:0] right_val,
    output logic signed [VALUE_W-1:0] val,
    output logic signed [VALUE_W-1:0] rd_val
);

    localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(IDX);

    logic signed [VALUE_W-1:0] val_reg;
    logic signed [VALUE_W-1:0] val_next;
    logic                      at_idx;
    logic                      above_idx;

    assign at_idx    = (idx == MY_IDX);
    assign above_idx = (MY_IDX > idx);

    // Take the new value, the left neighbor on insert, the right one on remove
    always_comb begin
        val_next = val_reg;
        if (cmd.ins) begin
            if (at_idx) begin
                val_next = value_in;
            end else if (above_idx) begin
                val_next = left_val;
            end
        end else if (cmd.rem) begin
            if (at_idx || above_idx) begin
                val_next = right_val;
            end
        end
    end

    always_ff @(posedge aclk) begin
        val_reg <= val_next;
    end

    assign val    = val_reg;
    // Drive the stored value onto the read tree only when addressed
    assign rd_val = at_idx ? val_reg : '0;

endmodule

`default_nettype wire

[rtl/positional_list_store.sv]
// Channel | Ports                                  | Direction
// --------+----------------------------------------+----------
// command | s_valid s_ready s_mode s_position      | in
//         | s_value_in                             |
// result  | m_valid m_ready m_value_out m_count    | out
//         | m_status                               |
//
// One item per cycle while the result port is not stalled: every command
// completes in the cycle it is accepted, with all CAPACITY cells shifting in
// parallel, and its result sits in the output register from the next cycle.
// A new item is taken while the held result is taken in the same cycle.
// Synchronous active-low reset empties the store; cell contents are not
// cleared, since only slots below the count are ever read.
// A stalled result holds the command port off until it leaves.
`default_nettype none

module positional_list_store
    import plc_pkg::*;
#(
    parameter int CAPACITY = 16
) (
    input  wire                        aclk,
    input  wire                        aresetn,
    input  wire                        s_valid,
    output logic                       s_ready,
    input  wire  [MODE_W-1:0]          s_mode,
    input  wire  signed [POS_W-1:0]    s_position,
    input  wire  signed [VALUE_W-1:0]  s_value_in,
    output logic                       m_valid,
    input  wire                        m_ready,
    output logic signed [VALUE_W-1:0]  m_value_out,
    output logic [COUNT_W-1:0]         m_count,
    output logic [STATUS_W-1:0]        m_status
);

    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam logic [CNT_W-1:0] CAP_CNT = CNT_W'(CAPACITY);

    logic [CNT_W-1:0]           cnt_reg;
    logic [CNT_W-1:0]           cnt_next;
    logic                       m_valid_reg;
    logic                       m_valid_next;
    logic signed [VALUE_W-1:0]  m_value_out_reg;
    logic [COUNT_W-1:0]         m_count_reg;
    logic [STATUS_W-1:0]        m_status_reg;

    logic                       accept;
    logic                       full;
    logic                       empty;
    logic                       pos_le0;
    logic                       pos_ge_cnt;
    logic [CNT_W-1:0]           pos_idx;
    logic [CNT_W-1:0]           idx;
    cell_cmd_t                  cmd;
    logic signed [VALUE_W-1:0]  rd_data;
    logic signed [VALUE_W-1:0]  res_value;
    logic [STATUS_W-1:0]        res_status;

    logic signed [VALUE_W-1:0]  cell_val [CAPACITY];
    logic signed [VALUE_W-1:0]  cell_rd  [CAPACITY];

    assign s_ready = !m_valid_reg || m_ready;
    assign accept  = s_valid && s_ready;
    assign full    = (cnt_reg == CAP_CNT);
    assign empty   = (cnt_reg == '0);

    // Clamp the signed position against the count
    assign pos_le0    = s_position[POS_W-1] || (s_position == '0);
    assign pos_ge_cnt = !s_position[POS_W-1] &&
                        (POS_W'(s_position) >= POS_W'(cnt_reg));
    assign pos_idx    = s_position[CNT_W-1:0];

    // Decode the command into a slot index and a shift
    always_comb begin
        idx        = '0;
        cmd        = '0;
        res_status = STATUS_OK;
        cnt_next   = cnt_reg;
        case (s_mode)
            MODE_PUSH_FRONT, MODE_PUSH_BACK, MODE_INSERT_AT: begin
                if (s_mode == MODE_PUSH_BACK) begin
                    idx = cnt_reg;
                end else if (s_mode == MODE_INSERT_AT && !pos_le0) begin
                    idx = pos_ge_cnt ? cnt_reg : pos_idx;
                end
                if (full) begin
                    res_status = STATUS_FULL;
                end else begin
                    cmd.ins  = accept;
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            MODE_POP_FRONT, MODE_POP_BACK, MODE_REMOVE_AT: begin
                if (s_mode == MODE_POP_BACK) begin
                    idx = cnt_reg - 1'b1;
                end else if (s_mode == MODE_REMOVE_AT && !pos_le0) begin
                    idx = pos_idx;
                end
                if (empty || (s_mode == MODE_REMOVE_AT && !pos_le0 && pos_ge_cnt)) begin
                    res_status = STATUS_EMPTY;
                end else begin
                    cmd.rem  = accept;
                    cnt_next = cnt_reg - 1'b1;
                end
            end
            default: begin
                res_status = STATUS_OK;
            end
        endcase
    end

    // Row of cells, each handing its value to both neighbors
    for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
        plc_cell #(
            .IDX_W (CNT_W),
            .IDX   (i)
        ) u_cell (
            .aclk      (aclk),
            .cmd       (cmd),
            .idx       (idx),
            .value_in  (s_value_in),
            .left_val  ((i == 0) ? s_value_in : cell_val[(i == 0) ? 0 : i - 1]),
            .right_val ((i == CAPACITY - 1) ? s_value_in
                                            : cell_val[(i == CAPACITY - 1) ? i : i + 1]),
            .val       (cell_val[i]),
            .rd_val    (cell_rd[i])
        );
    end

    // Collect the addressed cell; all others drive zero
    always_comb begin
        rd_data = '0;
        for (int i = 0; i < CAPACITY; i++) begin
            rd_data = rd_data | cell_rd[i];
        end
    end

    assign res_value = cmd.rem ? rd_data : '0;

    // Hold the result until taken
    always_comb begin
        m_valid_next = m_valid_reg;
        if (accept) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
            if (accept) begin
                cnt_reg <= cnt_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            m_value_out_reg <= res_value;
            m_count_reg     <= COUNT_W'(cnt_next);
            m_status_reg    <= res_status;
        end
    end

    assign m_valid     = m_valid_reg;
    assign m_value_out = m_value_out_reg;
    assign m_count     = m_count_reg;
    assign m_status    = m_status_reg;

    // Count never runs past the number of cells
    a_cnt_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg <= CAP_CNT)
        else $error("entry count above capacity");

    // A dropped insert leaves the count at capacity
    a_full_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        accept && res_status == STATUS_FULL |=> cnt_reg == CAP_CNT)
        else $error("full insert changed the count");

    // Shifts happen only on accepted items, never both ways
    a_cmd_gate: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.ins || cmd.rem) |-> accept && !(cmd.ins && cmd.rem))
        else $error("cell shift without an accepted item");

endmodule

`default_nettype wire
